// File: rtl/core/pidc_pkg.sv
// pidc_pkg: shared types, widths and codes for the clamped PID controller.
// Used by pidc_div, pidc_dp, pidc_ctrl and pid_controller_clamped.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pidc_pkg;

  // Field and register widths
  localparam int VAL_W      = 32;  // Q16.16 values, limits, drive
  localparam int GAIN_W     = 24;  // Q8.16 gains
  localparam int DT_W       = 16;  // Q0.16 interval
  localparam int ERR_W      = VAL_W + 1;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int MAG_W      = ERR_W;          // |error difference| < 2^33
  localparam int Q_W        = MAG_W;          // divider quotient bits
  localparam int HI_W       = DT_W;           // dividend bits above the quotient window
  localparam int DIV_CNT_W  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = VAL_W;

  // Shared multiplier and rounding widths
  localparam int MA_W       = 41;             // multiplicand: error, increment, derivative
  localparam int MB_W       = GAIN_W + 1;     // multiplier: gain or zero-extended interval
  localparam int PROD_W     = 58;             // largest product magnitude is below 2^56
  localparam int FRAC_W     = 16;
  localparam int HALF_LSB   = 32768;
  localparam int RND_W      = MA_W;           // rounded Q.16 terms
  localparam int SUM_W      = 43;             // three-term sum before clamping

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_HIGH = 3'd4;

  // Reset values of the configuration registers
  localparam logic signed [GAIN_W-1:0] GAIN_P_RST     = 24'sd58982;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RST     = 24'sd117965;
  localparam logic signed [GAIN_W-1:0] GAIN_D_RST     = 24'sd0;
  localparam logic signed [VAL_W-1:0]  LIMIT_LOW_RST  = -32'sd6553600;
  localparam logic signed [VAL_W-1:0]  LIMIT_HIGH_RST = 32'sd6553600;

  // Shared multiplier operand selection
  localparam logic [1:0] MUL_ERR_GI = 2'd0;  // error * gain_i
  localparam logic [1:0] MUL_ERR_GP = 2'd1;  // error * gain_p
  localparam logic [1:0] MUL_INC_DT = 2'd2;  // rounded increment * interval
  localparam logic [1:0] MUL_DER_GD = 2'd3;  // derivative * gain_d

  typedef struct packed {
    logic signed [VAL_W-1:0] target;
    logic signed [VAL_W-1:0] measurement;
    logic [DT_W-1:0]         interval;
  } pidc_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] drive;
    logic                    zero_interval;
  } pidc_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load_in;
    logic [1:0] mul_sel;
    logic       diff_load;
    logic       div_start;
    logic       save_p;
    logic       int_add;
    logic       int_clamp;
    logic       deriv_load;
    logic       sum_load;
    logic       out_load;
  } pidc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_busy;
    logic zero_dt;
  } pidc_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/pidc_div.sv
// pidc_div: restoring divider, one quotient bit per cycle, with early overflow check.
// Divides mag * 2^16 by the interval; quotient is Q_W bits.
// Depends on pidc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pidc_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pidc_pkg::MAG_W-1:0]   mag,
  input  logic [pidc_pkg::DT_W-1:0]    divisor,
  output logic                         busy,
  output logic                         ovf,
  output logic [pidc_pkg::Q_W-1:0]     quo
);
  import pidc_pkg::*;

  localparam int LO_W = MAG_W - HI_W;

  logic [DT_W-1:0]      rem_r, rem_nxt;
  logic [Q_W-1:0]       shq_r, shq_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [DT_W:0]        trial;
  logic [DT_W:0]        trial_sub;
  logic                 ge;

  // Trial subtract of the partial remainder with the next dividend bit
  assign trial     = {rem_r, shq_r[Q_W-1]};
  assign trial_sub = trial - {1'b0, divisor};
  assign ge        = (trial >= {1'b0, divisor});

  always_comb begin
    rem_nxt  = rem_r;
    shq_nxt  = shq_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    ovf_nxt  = ovf_r;
    if (start) begin
      // High dividend bits already reach the divisor: quotient >= 2^Q_W
      ovf_nxt  = (mag[MAG_W-1 -: HI_W] >= divisor);
      busy_nxt = ~ovf_nxt;
      rem_nxt  = mag[MAG_W-1 -: HI_W];
      shq_nxt  = {mag[LO_W-1:0], {FRAC_W{1'b0}}};
      cnt_nxt  = DIV_CNT_W'(Q_W - 1);
    end else if (busy_r) begin
      rem_nxt = ge ? trial_sub[DT_W-1:0] : trial[DT_W-1:0];
      shq_nxt = {shq_r[Q_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    shq_r <= shq_nxt;
    cnt_r <= cnt_nxt;
    ovf_r <= ovf_nxt;
  end

  assign busy = busy_r;
  assign ovf  = ovf_r;
  assign quo  = shq_r;

endmodule

`default_nettype wire

// File: rtl/core/pidc_dp.sv
// pidc_dp: datapath of the clamped PID controller: configuration registers, state,
// shared multiplier with rounding stage, divider, clamps and output register.
// Depends on pidc_pkg and pidc_div.
`timescale 1ns / 1ps
`default_nettype none

module pidc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pidc_pkg::pidc_cmd_t               cmd,
  output pidc_pkg::pidc_sts_t               sts,
  input  pidc_pkg::pidc_in_t                in_data,
  input  logic                              cfg_we,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pidc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output pidc_pkg::pidc_out_t               out_data
);
  import pidc_pkg::*;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  // Configuration
  logic signed [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic signed [VAL_W-1:0]  lim_lo_r, lim_hi_r;

  // Controller state
  logic signed [VAL_W-1:0]  integ_r;
  logic signed [ERR_W-1:0]  last_err_r;

  // Per-item working registers
  logic signed [ERR_W-1:0]  err_r;
  logic [DT_W-1:0]          dt_r;
  logic                     zdt_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic [MAG_W-1:0]         mag_r;
  logic signed [PROD_W-1:0] mul_r;
  logic signed [RND_W-1:0]  rnd_r;
  logic signed [RND_W-1:0]  p_r;
  logic signed [SUM_W-1:0]  isum_r;
  logic signed [VAL_W-1:0]  deriv_r;
  logic signed [SUM_W-1:0]  sum_r;
  pidc_out_t                out_r;

  logic signed [MA_W-1:0]       mul_a;
  logic signed [MB_W-1:0]       mul_b;
  logic signed [MA_W+MB_W-1:0]  prod_full;
  logic signed [PROD_W-1:0]     rnd_sum;
  logic signed [PROD_W-1:0]     rnd_shift;
  logic [DIFF_W-1:0]            mag_full;
  logic signed [VAL_W-1:0]      deriv_nxt;
  logic                         div_busy, div_ovf;
  logic [Q_W-1:0]               div_quo;
  logic                         diff_neg;

  // Upper clamp first, then lower, so the lower limit wins when crossed
  function automatic logic signed [VAL_W-1:0] clamp_val(
    input logic signed [SUM_W-1:0] v,
    input logic signed [VAL_W-1:0] lo,
    input logic signed [VAL_W-1:0] hi
  );
    logic signed [SUM_W-1:0] lo_x;
    logic signed [SUM_W-1:0] hi_x;
    logic signed [SUM_W-1:0] r;
    lo_x = {{(SUM_W-VAL_W){lo[VAL_W-1]}}, lo};
    hi_x = {{(SUM_W-VAL_W){hi[VAL_W-1]}}, hi};
    r = v;
    if (r > hi_x) r = hi_x;
    if (r < lo_x) r = lo_x;
    return r[VAL_W-1:0];
  endfunction

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= GAIN_P_RST;
      gain_i_r <= GAIN_I_RST;
      gain_d_r <= GAIN_D_RST;
      lim_lo_r <= LIMIT_LOW_RST;
      lim_hi_r <= LIMIT_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN_P:     gain_p_r <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_I:     gain_i_r <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_D:     gain_d_r <= cfg_data[GAIN_W-1:0];
        CFG_LIMIT_LOW:  lim_lo_r <= cfg_data[VAL_W-1:0];
        CFG_LIMIT_HIGH: lim_hi_r <= cfg_data[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared multiplier operand select
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_ERR_GI: begin
        mul_a = {{(MA_W-ERR_W){err_r[ERR_W-1]}}, err_r};
        mul_b = {gain_i_r[GAIN_W-1], gain_i_r};
      end
      MUL_ERR_GP: begin
        mul_a = {{(MA_W-ERR_W){err_r[ERR_W-1]}}, err_r};
        mul_b = {gain_p_r[GAIN_W-1], gain_p_r};
      end
      MUL_INC_DT: begin
        mul_a = rnd_r;
        mul_b = {{(MB_W-DT_W){1'b0}}, dt_r};
      end
      MUL_DER_GD: begin
        mul_a = {{(MA_W-VAL_W){deriv_r[VAL_W-1]}}, deriv_r};
        mul_b = {gain_d_r[GAIN_W-1], gain_d_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_full = mul_a * mul_b;

  // Round Q.32 to Q.16, half up
  assign rnd_sum   = mul_r + PROD_W'(HALF_LSB);
  assign rnd_shift = rnd_sum >>> FRAC_W;

  // Magnitude of the error difference for the divider
  assign diff_neg = diff_r[DIFF_W-1];
  assign mag_full = diff_neg ? -diff_r : diff_r;

  // Derivative: zero for a zero interval, else sign the quotient and saturate to 32 bits
  always_comb begin
    if (zdt_r) begin
      deriv_nxt = '0;
    end else if (div_ovf) begin
      deriv_nxt = diff_neg ? VAL_MIN : VAL_MAX;
    end else if (!diff_neg) begin
      deriv_nxt = (div_quo > {1'b0, VAL_MAX}) ? VAL_MAX : div_quo[VAL_W-1:0];
    end else begin
      deriv_nxt = (div_quo > {1'b0, VAL_MIN}) ? VAL_MIN : VAL_W'(-div_quo);
    end
  end

  pidc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .mag     (mag_r),
    .divisor (dt_r),
    .busy    (div_busy),
    .ovf     (div_ovf),
    .quo     (div_quo)
  );

  // Integrator and last error
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      last_err_r <= '0;
    end else begin
      if (cmd.int_clamp) integ_r <= clamp_val(isum_r, lim_lo_r, lim_hi_r);
      if (cmd.diff_load) last_err_r <= err_r;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      err_r <= {in_data.target[VAL_W-1], in_data.target}
             - {in_data.measurement[VAL_W-1], in_data.measurement};
      dt_r  <= in_data.interval;
      zdt_r <= (in_data.interval == '0);
    end
    if (cmd.diff_load) begin
      diff_r <= {err_r[ERR_W-1], err_r} - {last_err_r[ERR_W-1], last_err_r};
    end
    mag_r <= mag_full[MAG_W-1:0];
    mul_r <= prod_full[PROD_W-1:0];
    rnd_r <= rnd_shift[RND_W-1:0];
    if (cmd.save_p) p_r <= rnd_r;
    if (cmd.int_add) begin
      isum_r <= {{(SUM_W-VAL_W){integ_r[VAL_W-1]}}, integ_r}
              + {{(SUM_W-RND_W){rnd_r[RND_W-1]}}, rnd_r};
    end
    if (cmd.deriv_load) deriv_r <= deriv_nxt;
    if (cmd.sum_load) begin
      sum_r <= {{(SUM_W-RND_W){p_r[RND_W-1]}}, p_r}
             + {{(SUM_W-VAL_W){integ_r[VAL_W-1]}}, integ_r}
             + {{(SUM_W-RND_W){rnd_r[RND_W-1]}}, rnd_r};
    end
    if (cmd.out_load) begin
      out_r.drive         <= clamp_val(sum_r, lim_lo_r, lim_hi_r);
      out_r.zero_interval <= zdt_r;
    end
  end

  assign sts.div_busy = div_busy;
  assign sts.zero_dt  = zdt_r;
  assign out_data     = out_r;

endmodule

`default_nettype wire

// File: rtl/core/pidc_ctrl.sv
// pidc_ctrl: sequencing state machine of the clamped PID controller.
// Drives datapath commands and both handshakes; holds the result valid flag.
// Depends on pidc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pidc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pidc_pkg::pidc_cmd_t   cmd,
  input  pidc_pkg::pidc_sts_t   sts
);
  import pidc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MI    = 4'd1;   // error * gain_i
  localparam logic [3:0] S_MP    = 4'd2;   // error * gain_p
  localparam logic [3:0] S_MD    = 4'd3;   // increment * interval, divider start
  localparam logic [3:0] S_SAVEP = 4'd4;
  localparam logic [3:0] S_IADD  = 4'd5;
  localparam logic [3:0] S_ICLMP = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;   // wait for the divider
  localparam logic [3:0] S_DSAT  = 4'd8;
  localparam logic [3:0] S_MDD   = 4'd9;   // derivative * gain_d
  localparam logic [3:0] S_RND   = 4'd10;
  localparam logic [3:0] S_SUM   = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MUL_ERR_GI;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MI;
        end
      end
      S_MI: begin
        cmd.mul_sel   = MUL_ERR_GI;
        cmd.diff_load = 1'b1;
        state_nxt     = S_MP;
      end
      S_MP: begin
        cmd.mul_sel = MUL_ERR_GP;
        state_nxt   = S_MD;
      end
      S_MD: begin
        cmd.mul_sel   = MUL_INC_DT;
        cmd.div_start = ~sts.zero_dt;
        state_nxt     = S_SAVEP;
      end
      S_SAVEP: begin
        cmd.save_p = 1'b1;
        state_nxt  = S_IADD;
      end
      S_IADD: begin
        cmd.int_add = 1'b1;
        state_nxt   = S_ICLMP;
      end
      S_ICLMP: begin
        cmd.int_clamp = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (!sts.div_busy) state_nxt = S_DSAT;
      end
      S_DSAT: begin
        cmd.deriv_load = 1'b1;
        state_nxt      = S_MDD;
      end
      S_MDD: begin
        cmd.mul_sel = MUL_DER_GD;
        state_nxt   = S_RND;
      end
      S_RND: begin
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum_load = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        // Load the output register once it is empty or being drained
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid flag
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: rtl/core/pid_controller_clamped.sv
// pid_controller_clamped: fixed-point PID controller with clamped integrator and drive.
// Top level; joins the pidc_ctrl state machine and the pidc_dp datapath.
// Depends on pidc_pkg, pidc_ctrl, pidc_dp.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data): setpoint and measurement in Q16.16 and
//   the elapsed interval in Q0.16 seconds. Result channel (out_valid/out_ready/
//   out_data): clamped drive in Q16.16 and a flag set when the interval was zero.
//   Configuration port (cfg_we/cfg_index/cfg_data): gains and limits, one write per
//   cycle with no wait; write only while no item is in flight.
//   The time from input transfer to out_valid is set mostly by the bit-serial divider
//   for the derivative, 33 quotient bits at one per cycle, plus the four passes through
//   the single shared multiplier; it is shorter when the interval is zero or the
//   divider sees at start that the derivative saturates.
//   One item is processed at a time. A finished result sits in the output register,
//   and the next item is taken while it waits; if the receiver still stalls when the
//   following result is ready, that item holds in the last step until out_ready.
//   Reset (synchronous, rst_n low) clears the integrator and last error, restores the
//   default gains and limits, and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module pid_controller_clamped (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  pidc_pkg::pidc_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pidc_pkg::pidc_out_t               out_data,
  input  logic                              cfg_we,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pidc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pidc_pkg::*;

  pidc_cmd_t cmd;
  pidc_sts_t sts;

  pidc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  pidc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
